### sv/bitmap_page_allocator_core_defines.svh
// ----------------------------------------------------------------------------
// bitmap_page_allocator_core_defines
// assertion macros shared by the allocator checks
// ----------------------------------------------------------------------------
`ifndef BITMAP_PAGE_ALLOCATOR_CORE_DEFINES_SVH
`define BITMAP_PAGE_ALLOCATOR_CORE_DEFINES_SVH

// same-cycle implication, clocked on clk, off during reset
`define BPA_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, clocked on clk, off during reset
`define BPA_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### sv/bpa_pkg.sv
// ----------------------------------------------------------------------------
// bpa_pkg
// widths and codes shared by the bitmap page allocator files
// ----------------------------------------------------------------------------
package bpa_pkg;

	localparam int PAGE_W   = 13;
	localparam int IDX_W    = 12;
	localparam int STATUS_W = 2;
	localparam int DATA_W   = 16;

	localparam logic [PAGE_W-1:0] LIMIT_RESET = 13'd4096;

	typedef logic [STATUS_W-1:0] status_t;

	localparam status_t ST_OK        = 2'd0;
	localparam status_t ST_FULL      = 2'd1;
	localparam status_t ST_BAD_INDEX = 2'd2;

	localparam logic MODE_ALLOC = 1'b0;
	localparam logic MODE_FREE  = 1'b1;

endpackage

### sv/bpa_ram.sv
// ----------------------------------------------------------------------------
// bpa_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
module bpa_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 64,
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

### sv/bpa_word_scan.sv
// ----------------------------------------------------------------------------
// bpa_word_scan
// finds the lowest clear bit of one bitmap word inside a window [lo, hi)
// ----------------------------------------------------------------------------
module bpa_word_scan #(
	parameter int WORD_BITS = 64,
	localparam int BIT_W = $clog2(WORD_BITS)
) (
	input  logic [WORD_BITS-1:0] word,
	input  logic [BIT_W-1:0]     lo,
	input  logic [BIT_W:0]       hi,
	output logic                 hit,
	output logic [BIT_W-1:0]     pos
);

	always_comb begin
		hit = 1'b0;
		pos = '0;
		// walk downwards so the lowest qualifying bit wins
		for (int i = WORD_BITS - 1; i >= 0; i--) begin
			if (!word[i] && (BIT_W'(i) >= lo) && ((BIT_W + 1)'(i) < hi)) begin
				hit = 1'b1;
				pos = BIT_W'(i);
			end
		end
	end

endmodule

### sv/bitmap_page_allocator_core.sv
// ----------------------------------------------------------------------------
// bitmap_page_allocator_core
// next-fit page allocator over a used-page bitmap held in ram
// ----------------------------------------------------------------------------
// After reset the block sweeps the bitmap ram clear, one word a cycle, with
// s_tready low; configuration writes are taken throughout. A request is one
// beat: s_tuser is the mode (0 allocate, 1 free) and s_tdata holds the page
// index. The block then works on that request alone with s_tready low. An
// allocate reads one bitmap word per cycle through the single ram read port
// and the single word scanner, from the word holding the scan start up to
// the first clear page or the page limit (at most 64 words with the
// defaults). A free reads the word and writes it back with the page bit
// cleared; requests rejected up front go straight to the result. The result
// sits in an output register, so a new request can be taken while the
// previous one is still waiting on m_tready. MAP_WORD_BITS must be a power
// of two.
module bitmap_page_allocator_core import bpa_pkg::*; #(
	parameter int MAX_PAGES     = 4096,
	parameter int MAP_WORD_BITS = 64
) (
	input  logic              clk,
	input  logic              arst_n,
	// s_tdata: page_index [11:0], zero [15:12]
	// s_tuser: mode [0]
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [DATA_W-1:0] s_tdata,
	input  logic [0:0]        s_tuser,
	// m_tdata: granted_page [11:0], zero [15:12]
	// m_tuser: status [1:0]
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [DATA_W-1:0] m_tdata,
	output logic [STATUS_W-1:0] m_tuser,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [PAGE_W-1:0] cfg_data
);

	localparam int MAP_WORDS = (MAX_PAGES + MAP_WORD_BITS - 1) / MAP_WORD_BITS;
	localparam int BIT_W     = $clog2(MAP_WORD_BITS);
	localparam int ADDR_W    = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
	localparam int CNT_W     = BIT_W + 1;

	localparam logic [16:0]       MAX_PAGES_V = 17'(MAX_PAGES);
	localparam logic [CNT_W-1:0]  WORD_BITS_V = CNT_W'(MAP_WORD_BITS);
	localparam logic [PAGE_W-1:0] WORD_SPAN   = PAGE_W'(MAP_WORD_BITS);
	localparam logic [PAGE_W-1:0] BIT_MASK    = PAGE_W'(MAP_WORD_BITS - 1);
	localparam logic [ADDR_W-1:0] LAST_WORD   = ADDR_W'(MAP_WORDS - 1);

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_SCAN,
		S_FREE,
		S_DONE
	} state_t;

	state_t              state_q;
	logic [PAGE_W-1:0]   page_limit_q;
	logic [PAGE_W-1:0]   lim_q;
	logic [PAGE_W-1:0]   scan_start_q;
	logic [PAGE_W-1:0]   cur_q;
	logic [IDX_W-1:0]    idx_q;
	logic [ADDR_W-1:0]   clr_q;
	logic [IDX_W-1:0]    res_page_q;
	status_t             res_status_q;
	logic                m_tvalid_q;
	logic [IDX_W-1:0]    m_page_q;
	status_t             m_status_q;

	logic [PAGE_W-1:0]        lim_eff;
	logic [IDX_W-1:0]         in_page;
	logic [PAGE_W-1:0]        word_base;
	logic [PAGE_W-1:0]        span;
	logic [CNT_W-1:0]         hi;
	logic [PAGE_W:0]          nxt_base;
	logic                     nxt_end;
	logic                     hit;
	logic [BIT_W-1:0]         hit_pos;
	logic [PAGE_W-1:0]        granted;
	logic [MAP_WORD_BITS-1:0] set_mask;
	logic [MAP_WORD_BITS-1:0] clr_mask;

	logic                     ram_we;
	logic [ADDR_W-1:0]        ram_waddr;
	logic [MAP_WORD_BITS-1:0] ram_wdata;
	logic                     ram_re;
	logic [ADDR_W-1:0]        ram_raddr;
	logic [MAP_WORD_BITS-1:0] ram_rdata;

	assign s_tready  = (state_q == S_IDLE);
	assign cfg_ready = 1'b1;
	assign m_tvalid  = m_tvalid_q;
	assign m_tdata   = {{(DATA_W - IDX_W){1'b0}}, m_page_q};
	assign m_tuser   = m_status_q;

	assign in_page = s_tdata[IDX_W-1:0];

	// a limit above the bitmap size acts as the bitmap size
	assign lim_eff = ({4'b0, page_limit_q} > MAX_PAGES_V) ? PAGE_W'(MAX_PAGES_V) : page_limit_q;

	assign word_base = cur_q & ~BIT_MASK;
	assign span      = lim_q - word_base;
	assign hi        = (span >= WORD_SPAN) ? WORD_BITS_V : span[CNT_W-1:0];
	assign nxt_base  = {1'b0, word_base} + {1'b0, WORD_SPAN};
	assign nxt_end   = (nxt_base >= {1'b0, lim_q});
	assign granted   = word_base | PAGE_W'(hit_pos);
	assign set_mask  = MAP_WORD_BITS'(1) << hit_pos;
	assign clr_mask  = MAP_WORD_BITS'(1) << idx_q[BIT_W-1:0];

	bpa_word_scan #(
		.WORD_BITS (MAP_WORD_BITS)
	) u_scan (
		.word (ram_rdata),
		.lo   (cur_q[BIT_W-1:0]),
		.hi   (hi),
		.hit  (hit),
		.pos  (hit_pos)
	);

	bpa_ram #(
		.WIDTH (MAP_WORD_BITS),
		.DEPTH (MAP_WORDS)
	) u_map (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = ADDR_W'(word_base >> BIT_W);
		ram_wdata = '0;
		ram_re    = 1'b0;
		ram_raddr = ADDR_W'(scan_start_q >> BIT_W);
		case (state_q)
			S_CLEAR: begin
				ram_we    = 1'b1;
				ram_waddr = clr_q;
			end
			S_IDLE: begin
				if (s_tvalid) begin
					ram_re = 1'b1;
					if (s_tuser[0] == MODE_FREE) begin
						ram_raddr = ADDR_W'(in_page >> BIT_W);
					end
				end
			end
			S_SCAN: begin
				if (hit) begin
					ram_we    = 1'b1;
					ram_wdata = ram_rdata | set_mask;
				end else begin
					ram_re    = !nxt_end;
					ram_raddr = ADDR_W'(nxt_base >> BIT_W);
				end
			end
			S_FREE: begin
				ram_we    = 1'b1;
				ram_waddr = ADDR_W'(idx_q >> BIT_W);
				ram_wdata = ram_rdata & ~clr_mask;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			page_limit_q <= LIMIT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			page_limit_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_CLEAR;
			clr_q        <= '0;
			scan_start_q <= '0;
			lim_q        <= '0;
			cur_q        <= '0;
			idx_q        <= '0;
			res_page_q   <= '0;
			res_status_q <= ST_OK;
			m_tvalid_q   <= 1'b0;
			m_page_q     <= '0;
			m_status_q   <= ST_OK;
		end else begin
			// in S_DONE the output register is handled by the load below
			if (m_tvalid_q && m_tready && (state_q != S_DONE)) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + ADDR_W'(1);
					if (clr_q == LAST_WORD) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (s_tvalid) begin
						lim_q      <= lim_eff;
						idx_q      <= in_page;
						cur_q      <= scan_start_q;
						res_page_q <= '0;
						if (s_tuser[0] == MODE_ALLOC) begin
							if (scan_start_q < lim_eff) begin
								state_q <= S_SCAN;
							end else begin
								res_status_q <= ST_FULL;
								state_q      <= S_DONE;
							end
						end else begin
							if ({1'b0, in_page} < lim_eff) begin
								state_q <= S_FREE;
							end else begin
								res_status_q <= ST_BAD_INDEX;
								state_q      <= S_DONE;
							end
						end
					end
				end
				S_SCAN: begin
					if (hit) begin
						res_page_q   <= granted[IDX_W-1:0];
						res_status_q <= ST_OK;
						if (granted == scan_start_q) begin
							scan_start_q <= granted + PAGE_W'(1);
						end
						state_q <= S_DONE;
					end else if (nxt_end) begin
						res_status_q <= ST_FULL;
						state_q      <= S_DONE;
					end else begin
						cur_q <= nxt_base[PAGE_W-1:0];
					end
				end
				S_FREE: begin
					scan_start_q <= {1'b0, idx_q};
					res_status_q <= ST_OK;
					state_q      <= S_DONE;
				end
				S_DONE: begin
					// hold the result until the output register is free
					if (!m_tvalid_q || m_tready) begin
						m_tvalid_q <= 1'b1;
						m_page_q   <= res_page_q;
						m_status_q <= res_status_q;
						state_q    <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

### sv/bpa_checker.sv
// ----------------------------------------------------------------------------
// bpa_checker
// port-level checks for the bitmap page allocator, bound to the top level
// ----------------------------------------------------------------------------
`include "bitmap_page_allocator_core_defines.svh"

module bpa_checker import bpa_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              s_tvalid,
	input logic              s_tready,
	input logic              m_tvalid,
	input logic              m_tready,
	input logic [DATA_W-1:0] m_tdata,
	input logic [STATUS_W-1:0] m_tuser
);

	// one request at a time: the slave side closes after every accepted beat
	`BPA_ASSERT_NEXT(a_busy_after_beat, s_tvalid && s_tready, !s_tready, "tready stayed high after a request beat")

	// a failed request never reports a page
	`BPA_ASSERT_NOW(a_zero_page_on_fail, m_tvalid && (m_tuser != ST_OK), m_tdata == '0, "nonzero page with a failure status")

	// a result only appears after the block has been busy
	`BPA_ASSERT_NOW(a_result_after_work, $rose(m_tvalid), !$past(s_tready), "result beat without preceding work")

	`BPA_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled result beat changed")

endmodule

bind bitmap_page_allocator_core bpa_checker u_bpa_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);

### tb/tb_bitmap_page_allocator_core.sv
// ----------------------------------------------------------------------------
// tb_bitmap_page_allocator_core
// self-checking bench for the next-fit bitmap page allocator
// ----------------------------------------------------------------------------
// Requests go in as single beats. A scoreboard keeps its own copy of the
// page bitmap, the scan start and the page limit. It works out each answer
// when the request is taken and matches the answers in order as they leave.
// A directed part covers the corner cases. Random phases follow, each with
// its own page limit (not all distinct), and mix allocate runs with frees
// of held pages and stray frees. The sender works in bursts and the receiver
// stalls, so backpressure is exercised throughout.
module tb_bitmap_page_allocator_core;
	import bpa_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int PAGE_COUNT  = 4096;
	localparam int WORD_BITS   = 64;
	localparam int HOLD_CYCLES = 400;
	localparam int MAX_SHOWN   = 50;

	typedef struct packed {
		logic [IDX_W-1:0] page;
		status_t          status;
	} page_grant_t;

	typedef enum int {RX_FLOW, RX_HALF, RX_SPARSE, RX_PERIODIC} rx_style_t;

	class page_map_scoreboard;
		bit [PAGE_COUNT-1:0] used_pages;
		bit [PAGE_W-1:0]     scan_start;
		bit [PAGE_W-1:0]     page_limit;
		page_grant_t         pending_q[$];
		int                  mismatches;

		function new();
			used_pages = '0;
			scan_start = '0;
			page_limit = LIMIT_RESET;
			mismatches = 0;
		endfunction

		function void set_limit(bit [PAGE_W-1:0] value);
			page_limit = value;
		endfunction

		// works out the answer for a request just taken and queues it
		function page_grant_t note_request(logic mode, bit [IDX_W-1:0] index);
			page_grant_t grant;
			int          lim;
			int          p;
			lim = (page_limit > PAGE_COUNT) ? PAGE_COUNT : int'(page_limit);
			grant.page = '0;
			if (mode == MODE_ALLOC) begin
				grant.status = ST_FULL;
				// no wrap: clear pages below the scan start are never seen
				for (p = int'(scan_start); p < lim; p++) begin
					if (!used_pages[p]) begin
						grant.page = IDX_W'(p);
						grant.status = ST_OK;
						break;
					end
				end
				if (grant.status == ST_OK) begin
					if (int'(grant.page) == int'(scan_start))
						scan_start = scan_start + 1'b1;
					used_pages[grant.page] = 1'b1;
				end
			end else if (int'(index) >= lim) begin
				grant.status = ST_BAD_INDEX;
			end else begin
				used_pages[index] = 1'b0;
				scan_start = PAGE_W'(index);
				grant.status = ST_OK;
			end
			pending_q.push_back(grant);
			return grant;
		endfunction

		task report_mismatch(string what);
			mismatches++;
			if (mismatches <= MAX_SHOWN)
				$display("mismatch at %0t: %s", $realtime, what);
		endtask

		task check_result(logic [DATA_W-1:0] data, status_t status);
			page_grant_t want;
			if (pending_q.size() == 0) begin
				report_mismatch($sformatf("unexpected beat, page %0d status %0d",
					data[IDX_W-1:0], status));
				return;
			end
			want = pending_q.pop_front();
			if (data[IDX_W-1:0] !== want.page)
				report_mismatch($sformatf("granted page %0d, wanted %0d",
					data[IDX_W-1:0], want.page));
			if (status !== want.status)
				report_mismatch($sformatf("status %0d, wanted %0d", status, want.status));
			if (data[DATA_W-1:IDX_W] !== '0)
				report_mismatch($sformatf("padding bits %h not zero", data[DATA_W-1:IDX_W]));
		endtask
	endclass

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              s_tvalid = 1'b0;
	logic              s_tready;
	logic [DATA_W-1:0] s_tdata = '0;
	logic [0:0]        s_tuser = '0;
	logic              m_tvalid;
	logic              m_tready = 1'b0;
	logic [DATA_W-1:0] m_tdata;
	logic [STATUS_W-1:0] m_tuser;
	logic              cfg_valid = 1'b0;
	logic              cfg_ready;
	logic [PAGE_W-1:0] cfg_data = '0;

	page_map_scoreboard sb = new();

	// sender side state, touched only by the stimulus process
	bit               req_live;
	bit               cfg_live;
	int               burst_left;
	logic [IDX_W-1:0] held_pages[$];

	// long receiver hold-offs asked for by the stimulus
	int        hold_requests = 0;
	int        holds_started;
	int        hold_left;
	int        stretch_left;
	int        rx_phase;
	rx_style_t rx_style;

	bitmap_page_allocator_core #(
		.MAX_PAGES     (PAGE_COUNT),
		.MAP_WORD_BITS (WORD_BITS)
	) u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// receiver: checks each result beat and stalls in stretches of its own
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			sb.check_result(m_tdata, m_tuser);
		rx_phase++;
		if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else if (holds_started != hold_requests) begin
			holds_started++;
			hold_left = HOLD_CYCLES;
			m_tready <= 1'b0;
		end else begin
			if (stretch_left == 0) begin
				rx_style = rx_style_t'($urandom_range(0, 3));
				stretch_left = $urandom_range(10, 150);
			end else begin
				stretch_left--;
			end
			case (rx_style)
				RX_FLOW:     m_tready <= 1'b1;
				RX_HALF:     m_tready <= 1'($urandom_range(0, 1));
				RX_SPARSE:   m_tready <= ($urandom_range(0, 5) == 0);
				default:     m_tready <= (rx_phase[2:0] != 3'b111) && (rx_phase[2:0] != 3'b011);
			endcase
		end
	end

	// lower whatever is still offered before time moves on
	task automatic release_offers();
		if (req_live) begin
			s_tvalid <= 1'b0;
			req_live = 1'b0;
		end
		if (cfg_live) begin
			cfg_valid <= 1'b0;
			cfg_live = 1'b0;
		end
	endtask

	task automatic wait_results_drained();
		release_offers();
		while (sb.pending_q.size() != 0) begin
			@(posedge clk);
		end
	endtask

	task automatic pace_sender();
		int gap;
		if (burst_left > 0) begin
			burst_left--;
			return;
		end
		release_offers();
		gap = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 80) : $urandom_range(1, 6);
		repeat (gap) @(posedge clk);
		burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 120)
			: $urandom_range(0, 12);
	endtask

	task automatic send_request(logic mode, logic [IDX_W-1:0] index);
		page_grant_t grant;
		if (cfg_live) begin
			cfg_valid <= 1'b0;
			cfg_live = 1'b0;
		end
		s_tvalid <= 1'b1;
		s_tuser  <= mode;
		s_tdata  <= DATA_W'(index);
		req_live = 1'b1;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		grant = sb.note_request(mode, index);
		if (mode == MODE_ALLOC && grant.status == ST_OK)
			held_pages.push_back(grant.page);
		pace_sender();
	endtask

	task automatic write_page_limit(logic [PAGE_W-1:0] value);
		if (req_live) begin
			s_tvalid <= 1'b0;
			req_live = 1'b0;
		end
		while (sb.pending_q.size() != 0) begin
			release_offers();
			@(posedge clk);
		end
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		cfg_live = 1'b1;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		sb.set_limit(value);
	endtask

	task automatic run_phase(logic [PAGE_W-1:0] limit, int count, bit stress);
		int               eff;
		int               roll;
		int               n;
		int               k;
		logic [IDX_W-1:0] index;
		write_page_limit(limit);
		eff = (limit > PAGE_COUNT) ? PAGE_COUNT : int'(limit);
		for (n = 0; n < count; n++) begin
			// receiver holds off while the sender keeps offering beats
			if (stress && n == count / 3) begin
				hold_requests <= hold_requests + 1;
				burst_left = 60;
			end
			if (stress && n == (2 * count) / 3)
				wait_results_drained();
			roll = $urandom_range(0, 99);
			if (roll < 55) begin
				send_request(MODE_ALLOC, IDX_W'($urandom_range(0, 4095)));
			end else if (roll < 78 && held_pages.size() > 0) begin
				k = $urandom_range(0, held_pages.size() - 1);
				index = held_pages[k];
				held_pages.delete(k);
				send_request(MODE_FREE, index);
			end else if (roll < 90 && eff > 0) begin
				send_request(MODE_FREE, IDX_W'($urandom_range(0, eff - 1)));
			end else begin
				// stray frees, often at or past the limit
				if ($urandom_range(0, 1) == 0 && eff < PAGE_COUNT)
					index = IDX_W'(eff);
				else
					index = IDX_W'($urandom_range(0, 4095));
				send_request(MODE_FREE, index);
			end
		end
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// reset limit, fresh map
		send_request(MODE_ALLOC, '0);
		send_request(MODE_ALLOC, 12'hFFF);
		send_request(MODE_FREE, 12'd4095);
		send_request(MODE_ALLOC, '0);
		send_request(MODE_ALLOC, '0);
		send_request(MODE_FREE, '0);
		send_request(MODE_ALLOC, '0);
		send_request(MODE_ALLOC, '0);
		send_request(MODE_FREE, 12'd2000);
		send_request(MODE_FREE, 12'd2000);

		// single page
		write_page_limit(13'd1);
		send_request(MODE_ALLOC, '0);
		send_request(MODE_FREE, '0);
		send_request(MODE_ALLOC, '0);
		send_request(MODE_ALLOC, '0);
		send_request(MODE_FREE, 12'd1);
		send_request(MODE_FREE, 12'd4095);

		// zero limit
		write_page_limit(13'd0);
		send_request(MODE_ALLOC, 12'hFFF);
		send_request(MODE_FREE, '0);

		// limit above capacity
		write_page_limit(13'h1FFF);
		send_request(MODE_FREE, 12'd4095);
		send_request(MODE_ALLOC, '0);
		send_request(MODE_ALLOC, '0);

		// scan near the top of a one word map, clear pages left below it
		write_page_limit(13'd64);
		send_request(MODE_FREE, 12'd63);
		send_request(MODE_ALLOC, '0);
		send_request(MODE_ALLOC, '0);

		run_phase(13'd64, 190, 1'b1);
		run_phase(13'd4096, 220, 1'b1);
		run_phase(13'd1, 60, 1'b0);
		run_phase(13'd130, 190, 1'b0);
		run_phase(13'h1FFF, 200, 1'b0);
		run_phase(13'd0, 40, 1'b0);
		run_phase(13'd200, 190, 1'b1);
		run_phase(13'd4097, 200, 1'b0);
		run_phase(13'd2900, 200, 1'b0);
		run_phase(PAGE_W'($urandom_range(2, 400)), 180, 1'b0);
		run_phase(13'd4096, 150, 1'b0);

		wait_results_drained();
		repeat (100) @(posedge clk);
		if (sb.mismatches == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

	initial begin
		#20_000_000;
		$display("TB_ERROR");
		$finish;
	end

endmodule
